// ----- rtl/core/tli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Shared widths, defaults and result region codes.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int DATA_W              = 32;
  localparam int COUNT_W             = 9;
  localparam int INDEX_W             = 8;
  localparam int REGION_W            = 2;

  typedef logic [REGION_W-1:0] region_t;

  localparam region_t REGION_INTERP = 2'd0;
  localparam region_t REGION_BELOW  = 2'd1;
  localparam region_t REGION_ABOVE  = 2'd2;
  localparam region_t REGION_EMPTY  = 2'd3;

endpackage

// ----- rtl/core/tli_interp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolation unit
// Computes fa + trunc((fb - fa) * (w - la) / (lb - la)) with a multiply
// state and a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tli_interp
  import tli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] fa,
  input  logic signed [DATA_W-1:0] fb,
  input  logic        [DATA_W-1:0] la,
  input  logic        [DATA_W-1:0] lb,
  input  logic        [DATA_W-1:0] w,
  output logic                     done,
  output logic        [DATA_W-1:0] result
);

  localparam int CNT_W = $clog2(DATA_W);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_FIN  = 2'd3;

  logic [1:0]          state;
  logic [CNT_W-1:0]    cnt;
  logic [DATA_W-1:0]   base;
  logic                neg;
  logic [DATA_W-1:0]   mag;
  logic [DATA_W-1:0]   offs;
  logic [DATA_W-1:0]   den;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   low;

  logic [DATA_W:0]     diff;
  logic [DATA_W:0]     ndiff;
  logic [2*DATA_W-1:0] product;
  logic [DATA_W:0]     shifted;
  logic [DATA_W:0]     trial;
  logic                qbit;

  assign diff    = {fb[DATA_W-1], fb} - {fa[DATA_W-1], fa};
  assign ndiff   = -diff;
  assign product = (2*DATA_W)'(mag) * (2*DATA_W)'(offs);
  assign shifted = {rem, low[DATA_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign qbit    = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            base  <= fa;
            neg   <= diff[DATA_W];
            mag   <= diff[DATA_W] ? ndiff[DATA_W-1:0] : diff[DATA_W-1:0];
            offs  <= w - la;
            den   <= lb - la;
            state <= U_MUL;
          end
        end
        U_MUL: begin
          rem   <= product[2*DATA_W-1:DATA_W];
          low   <= product[DATA_W-1:0];
          cnt   <= '0;
          state <= U_DIV;
        end
        U_DIV: begin
          rem <= qbit ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
          low <= {low[DATA_W-2:0], qbit};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DATA_W - 1)) begin
            state <= U_FIN;
          end
        end
        U_FIN: begin
          result <= neg ? (base - low) : (base + low);
          done   <= 1'b1;
          state  <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/table_linear_interpolator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator
// Holds (wavelength, flux) points and answers queries by clamping or by
// linear interpolation between the bracketing pair.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. With mode 0 it writes
// one point into the table in the accept cycle, leaves busy low and gives no
// result. With mode 1 it queries the flux at a wavelength, and the answer
// appears on flux_out and region, marked by done high for a single cycle.
// point_count is to be written through cfg_we and cfg_data only while no query
// runs; the user must keep to this, the block itself does not enforce it. An
// empty table is answered at accept. Otherwise the first point is read to clamp
// below it, then the last point to clamp at or above it; else the scan reads one
// table entry per cycle from the single read port up to the bracketing entry,
// and the interpolation unit then does one multiply, 32 divide steps of one
// quotient bit each and a final add.
// Reset clears point_count and the control state; table contents are kept
// undefined until written. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module table_linear_interpolator_unit
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic        [COUNT_W-1:0] cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic        [INDEX_W-1:0] point_index,
  input  logic        [DATA_W-1:0]  wavelength,
  input  logic signed [DATA_W-1:0]  flux_in,
  output logic                      done,
  output logic signed [DATA_W-1:0]  flux_out,
  output region_t                   region
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (NW > COUNT_W) ? NW : COUNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2*DATA_W-1:0] mem [TABLE_DEPTH];
  logic [2*DATA_W-1:0] rdata;
  logic [AW-1:0]       raddr;

  logic [2:0]          state;
  logic [COUNT_W-1:0]  point_count;
  logic [NW-1:0]       n;
  logic [AW-1:0]       idx;
  logic [DATA_W-1:0]   qw;
  logic [DATA_W-1:0]   prev_l;
  logic [DATA_W-1:0]   prev_f;

  logic [XW-1:0]       count_ext;
  logic [XW-1:0]       n_clamp;
  logic [XW-1:0]       index_ext;
  logic [NW-1:0]       nm1;
  logic [DATA_W-1:0]   rd_l;
  logic [DATA_W-1:0]   rd_f;
  logic                accept;
  logic                unit_start;
  logic                unit_done;
  logic [DATA_W-1:0]   unit_result;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign count_ext = XW'(point_count);
  assign n_clamp   = (count_ext > XW'(TABLE_DEPTH)) ? XW'(TABLE_DEPTH) : count_ext;
  assign index_ext = XW'(point_index);
  assign nm1       = n - NW'(1);
  assign rd_l      = rdata[DATA_W-1:0];
  assign rd_f      = rdata[2*DATA_W-1:DATA_W];
  assign unit_start = (state == S_SCAN) && (qw < rd_l);

  always_comb begin
    case (state)
      S_FIRST: raddr = nm1[AW-1:0];
      S_LAST:  raddr = AW'(1);
      S_SCAN:  raddr = idx + 1'b1;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && !mode && (index_ext < XW'(TABLE_DEPTH))) begin
      mem[index_ext[AW-1:0]] <= {flux_in, wavelength};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && mode) begin
            qw <= wavelength;
            n  <= NW'(n_clamp);
            if (n_clamp == '0) begin
              flux_out <= '0;
              region   <= REGION_EMPTY;
              done     <= 1'b1;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          if (qw < rd_l) begin
            flux_out <= rd_f;
            region   <= REGION_BELOW;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            prev_l <= rd_l;
            prev_f <= rd_f;
            state  <= S_LAST;
          end
        end
        S_LAST: begin
          if (qw >= rd_l) begin
            flux_out <= rd_f;
            region   <= REGION_ABOVE;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            idx   <= AW'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (qw < rd_l) begin
            state <= S_WAIT;
          end else if (idx == nm1[AW-1:0]) begin
            flux_out <= rd_f;
            region   <= REGION_ABOVE;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            prev_l <= rd_l;
            prev_f <= rd_f;
            idx    <= idx + 1'b1;
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            flux_out <= unit_result;
            region   <= REGION_INTERP;
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tli_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .fa     (prev_f),
    .fb     (rd_f),
    .la     (prev_l),
    .lb     (rd_l),
    .w      (qw),
    .done   (unit_done),
    .result (unit_result)
  );

  a_done_from_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || (start && mode)))
    else $error("result strobe without a query in progress");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a query is still running");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !mode) |=> (!busy && !done))
    else $error("table write caused busy or a result");

  a_unit_idle_start: assert property (@(posedge clk) disable iff (rst)
    unit_start |=> (state == S_WAIT))
    else $error("interpolation started outside the scan");

endmodule

// ----- test/tli_query_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator query checker
// Follows the write and query items that the block accepts, keeps its own copy
// of the point table and of point_count, predicts the answer to every query
// and compares each done strobe, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tli_query_checker
  import tli_pkg::*;
#(
  parameter int DEPTH = DEFAULT_TABLE_DEPTH
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic        [COUNT_W-1:0] cfg_data,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      mode,
  input  logic        [INDEX_W-1:0] point_index,
  input  logic        [DATA_W-1:0]  wavelength,
  input  logic signed [DATA_W-1:0]  flux_in,
  input  logic                      done,
  input  logic signed [DATA_W-1:0]  flux_out,
  input  region_t                   region,
  output int                        error_count,
  output int                        answers_due
);

  typedef struct packed {
    logic signed [DATA_W-1:0] flux;
    region_t                  region;
  } tli_answer_t;

  logic        [DATA_W-1:0]  wl_table [DEPTH];
  logic signed [DATA_W-1:0]  fx_table [DEPTH];
  logic        [COUNT_W-1:0] point_count = '0;
  tli_answer_t               answer_q [$];
  int                        failures = 0;
  int                        pending = 0;

  assign error_count = failures;
  assign answers_due = pending;

  function automatic tli_answer_t predict_answer(input logic [DATA_W-1:0] w);
    tli_answer_t ans;
    int          n;
    logic [31:0] la;
    logic [31:0] lb;
    longint      fa;
    longint      diff;
    longint      res;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    bit          hit;
    n   = (point_count > DEPTH) ? DEPTH : int'(point_count);
    hit = 1'b0;
    if (n == 0) begin
      ans = '{32'sd0, REGION_EMPTY};
    end else if (w < wl_table[0]) begin
      ans = '{fx_table[0], REGION_BELOW};
    end else if (w >= wl_table[n-1]) begin
      ans = '{fx_table[n-1], REGION_ABOVE};
    end else begin
      ans = '{fx_table[n-1], REGION_ABOVE};
      for (int i = 0; i + 1 < n && !hit; i++) begin
        la = wl_table[i];
        lb = wl_table[i+1];
        if (w >= la && w < lb) begin
          hit  = 1'b1;
          fa   = longint'(fx_table[i]);
          diff = longint'(fx_table[i+1]) - fa;
          mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
          num  = mag * {32'd0, w - la};
          den  = {32'd0, lb - la};
          quo  = num / den;
          res  = (diff < 0) ? fa - longint'(quo) : fa + longint'(quo);
          ans  = '{res[31:0], REGION_INTERP};
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    tli_answer_t want;
    if (rst) begin
      point_count = '0;
      answer_q.delete();
    end else begin
      if (done) begin
        if (answer_q.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: answer with no query waiting, flux %h region %0d",
                     $time, flux_out, region);
          end
        end else begin
          want = answer_q.pop_front();
          if (want.flux !== flux_out || want.region !== region) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: answer mismatch, expected flux %h region %0d,",
                       $time, want.flux, want.region,
                       " got flux %h region %0d", flux_out, region);
            end
          end
        end
      end
      if (start && !busy) begin
        if (mode) begin
          answer_q.push_back(predict_answer(wavelength));
        end else if (point_index < DEPTH) begin
          wl_table[point_index] = wavelength;
          fx_table[point_index] = flux_in;
        end
      end
      if (cfg_we) begin
        point_count = cfg_data;
      end
    end
    pending = answer_q.size();
  end

endmodule

// ----- test/tb_table_linear_interpolator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator testbench
// Loads point tables of many sizes and shapes, sweeps point_count through its
// extremes and queries below, on, between and above the points with random
// pauses on the start side. The query checker predicts and checks every
// answer; this module makes the items and gives the verdict.
// ----------------------------------------------------------------------------
module tb_table_linear_interpolator_unit;
  import tli_pkg::*;

  localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
  localparam int ITEM_TARGET = 800;
  localparam int QUIET_LIMIT = 4000;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic        [COUNT_W-1:0] cfg_data = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      mode = 1'b0;
  logic        [INDEX_W-1:0] point_index = '0;
  logic        [DATA_W-1:0]  wavelength = '0;
  logic signed [DATA_W-1:0]  flux_in = '0;
  logic                      done;
  logic signed [DATA_W-1:0]  flux_out;
  region_t                   region;

  int                error_count;
  int                answers_due;
  int                quiet_cycles = 0;
  int                items_sent = 0;
  int                n_live = 0;
  bit                steady = 1'b0;
  logic [DATA_W-1:0] lam_copy [DEPTH];

  table_linear_interpolator_unit #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .point_index(point_index),
    .wavelength (wavelength),
    .flux_in    (flux_in),
    .done       (done),
    .flux_out   (flux_out),
    .region     (region)
  );

  tli_query_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .point_index(point_index),
    .wavelength (wavelength),
    .flux_in    (flux_in),
    .done       (done),
    .flux_out   (flux_out),
    .region     (region),
    .error_count(error_count),
    .answers_due(answers_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[table_linear_interpolator_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] pick_flux();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic m, input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] f);
    if (!steady && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    point_index <= idx;
    wavelength  <= w;
    flux_in     <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!m) begin
      lam_copy[idx] = w;
    end
    items_sent++;
  endtask

  task automatic write_point(input int idx, input logic [DATA_W-1:0] w,
                             input logic [DATA_W-1:0] f);
    send_item(1'b0, idx[INDEX_W-1:0], w, f);
  endtask

  task automatic ask(input logic [DATA_W-1:0] w);
    send_item(1'b1, INDEX_W'($urandom_range(0, 255)), w, $urandom);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(input int c);
    cfg_we   <= 1'b1;
    cfg_data <= c[COUNT_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    n_live = (c > DEPTH) ? DEPTH : c;
  endtask

  task automatic load_points(input int n, input int shift_lo);
    logic [32:0] acc;
    int          shift;
    shift = $urandom_range(shift_lo, 31);
    acc   = {1'b0, 32'($urandom >> $urandom_range(0, 31))};
    for (int i = 0; i < n; i++) begin
      write_point(i, acc[31:0], pick_flux());
      if ($urandom_range(9) != 0) begin
        acc = acc + {1'b0, 32'($urandom >> shift)};
      end
      if (acc[32]) begin
        acc = 33'h0_FFFF_FFFF;
      end
    end
  endtask

  task automatic query();
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int                i;
    int                r;
    r = $urandom_range(99);
    if (n_live >= 2 && r < 55) begin
      i  = $urandom_range(0, n_live - 2);
      lo = lam_copy[i];
      hi = lam_copy[i+1];
      w  = (hi > lo) ? lo + ($urandom % (hi - lo)) : lo;
    end else if (n_live >= 1 && r < 75) begin
      w = lam_copy[$urandom_range(0, n_live - 1)];
    end else if (n_live >= 1 && r < 82) begin
      w = lam_copy[0] - 1;
    end else begin
      w = $urandom;
    end
    ask(w);
  endtask

  task automatic mixed_items(input int q);
    repeat (q) begin
      if ($urandom_range(99) < 12) begin
        write_point($urandom_range(0, DEPTH - 1), $urandom, pick_flux());
      end else begin
        query();
      end
    end
  endtask

  initial begin
    int c;
    int r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    ask(32'h0000_0000);
    ask(32'hFFFF_FFFF);
    write_point(0, 32'h0000_1000, 32'h7FFF_FFFF);
    write_point(1, 32'h0000_5000, 32'h8000_0000);
    write_point(2, 32'h0000_5000, 32'h0001_0000);
    write_point(3, 32'hFFFF_FFFF, 32'hFFFF_0000);
    settle();
    set_count(1);
    ask(32'h0000_0000);
    ask(32'h0000_1000);
    ask(32'hFFFF_FFFF);
    settle();
    set_count(2);
    ask(32'h0000_2000);
    ask(32'h0000_4FFF);
    ask(32'h0000_5000);
    settle();
    set_count(4);
    ask(32'h0000_0FFF);
    ask(32'h0000_1000);
    ask(32'h0000_3000);
    ask(32'h0000_5000);
    ask(32'h8000_0000);
    ask(32'hFFFF_FFFE);
    ask(32'hFFFF_FFFF);
    write_point(3, 32'h0000_3000, 32'h0000_0000);
    ask(32'h0000_2000);
    ask(32'h0000_4000);

    settle();
    set_count(DEPTH);
    load_points(DEPTH, 8);
    mixed_items(30);
    settle();
    set_count((1 << COUNT_W) - 1);
    mixed_items(25);
    settle();
    set_count(0);
    mixed_items(6);

    while (items_sent < ITEM_TARGET) begin
      steady = (items_sent >= 420 && items_sent < 560);
      settle();
      r = $urandom_range(99);
      if (r < 8) begin
        c = 0;
      end else if (r < 16) begin
        c = 1;
      end else if (r < 22) begin
        c = $urandom_range(1) ? DEPTH : $urandom_range(DEPTH + 1, (1 << COUNT_W) - 1);
      end else begin
        c = $urandom_range(2, 16);
      end
      set_count(c);
      if (c >= 2 && c <= 16) begin
        load_points(c, 3);
      end
      mixed_items((c > 16) ? 15 : $urandom_range(20, 40));
    end

    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && answers_due == 0) begin
      $display("[table_linear_interpolator_unit] OK");
    end else begin
      $display("[table_linear_interpolator_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tli_pkg.sv
rtl/core/tli_interp.sv
rtl/core/table_linear_interpolator_unit.sv
test/tli_query_checker.sv
test/tb_table_linear_interpolator_unit.sv
